// File: rtl/arp_resolver_cache_assert.svh
// assertion macros for the arp resolver cache
`ifndef ARP_RESOLVER_CACHE_ASSERT_SVH
`define ARP_RESOLVER_CACHE_ASSERT_SVH
// property that holds on every clock edge out of reset
`define ARC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// implication checked on the next edge
`define ARC_ASSERT_NEXT(label, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (prop)) \
		else $error(msg);
`endif

// File: rtl/arc_pkg.sv
// shared types and codes of the arp resolver cache
`default_nettype none
package arc_pkg;
	localparam logic [1:0] MODE_RESOLVE = 2'd0;
	localparam logic [1:0] MODE_REPLY   = 2'd1;
	localparam logic [1:0] MODE_TICK    = 2'd2;
	localparam logic [1:0] MODE_CLEAR   = 2'd3;

	localparam logic [2:0] KIND_HIT      = 3'd0;
	localparam logic [2:0] KIND_SEND     = 3'd1;
	localparam logic [2:0] KIND_RESOLVED = 3'd2;
	localparam logic [2:0] KIND_FAILED   = 3'd3;
	localparam logic [2:0] KIND_FULL     = 3'd4;

	localparam logic [1:0] REG_LOCAL_IP     = 2'd0;
	localparam logic [1:0] REG_SUBNET_MASK  = 2'd1;
	localparam logic [1:0] REG_GATEWAY_IP   = 2'd2;
	localparam logic [1:0] REG_MAX_ATTEMPTS = 2'd3;
	localparam logic [3:0] MAX_ATTEMPTS_RST = 4'd3;

	// width of the caller tag kept in the pending list
	localparam int TAG_BITS = 8;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] ip_address;
		logic [47:0] mac_address;
		logic [7:0]  request_tag;
	} in_item_t;

	typedef struct packed {
		logic [2:0]  result_kind;
		logic [31:0] target_ip;
		logic [47:0] resolved_mac;
		logic [7:0]  result_tag;
		logic        last;
	} out_item_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [7:0]  tag;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CSCAN, ST_RESOLVE, ST_REPLY, ST_TICK, ST_EMIT
	} back_state_t;
endpackage
`default_nettype wire

// File: rtl/arc_front.sv
// front end: accepts items, picks the resolve target, pushes commands to the queue
`default_nettype none
module arc_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	output logic                   full,
	input  wire arc_pkg::in_item_t in_item,
	input  wire logic [31:0]       local_ip,
	input  wire logic [31:0]       subnet_mask,
	input  wire logic [31:0]       gateway_ip,
	output logic                   cmd_valid,
	input  wire logic              cmd_ready,
	output arc_pkg::cmd_t          cmd
);
	import arc_pkg::*;
	// two-entry command queue
	cmd_t       q_mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;
	cmd_t       c;
	logic       do_push, do_pop;

	always_comb begin
		c.mode = in_item.mode;
		c.ip   = in_item.ip_address;
		c.mac  = in_item.mac_address;
		c.tag  = in_item.request_tag;
		if (in_item.mode == MODE_RESOLVE &&
				((in_item.ip_address ^ local_ip) & subnet_mask) != 32'd0) begin
			c.ip = gateway_ip;
		end
	end

	assign full      = cnt_q[1];
	assign do_push   = push && !full;
	assign cmd_valid = cnt_q != 2'd0;
	assign do_pop    = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_mem_q[wr_ptr_q] <= c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
		end
	end
endmodule
`default_nettype wire

// File: rtl/arc_back.sv
// back end: cache and pending list, scans one entry per cycle and emits results
`default_nettype none
module arc_back #(
	parameter int CACHE_ENTRIES = 8,
	parameter int PENDING_SLOTS = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cmd_valid,
	output logic                     cmd_ready,
	input  wire arc_pkg::cmd_t       cmd,
	input  wire logic [3:0]          max_attempts,
	output logic                     empty,
	input  wire logic                pop,
	output arc_pkg::out_item_t       out_item,
	output logic                     idle
);
	import arc_pkg::*;
	localparam int CW = $clog2(CACHE_ENTRIES + 1);
	localparam int CI = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int PW = $clog2(PENDING_SLOTS + 1);
	localparam int PI = (PENDING_SLOTS > 1) ? $clog2(PENDING_SLOTS) : 1;

	logic [31:0]       cache_ip_q  [CACHE_ENTRIES];
	logic [47:0]       cache_mac_q [CACHE_ENTRIES];
	logic [CW-1:0]     cache_cnt_q;
	logic [31:0]       pend_ip_q   [PENDING_SLOTS];
	logic [TAG_BITS-1:0] pend_tag_q [PENDING_SLOTS];
	logic [3:0]        pend_att_q  [PENDING_SLOTS];
	logic [PW-1:0]     pend_cnt_q;

	back_state_t   state_q, state_d;
	back_state_t   ret_q;
	cmd_t          cmd_q;
	logic [CW-1:0] ci_q;
	logic [PW-1:0] pi_q;
	logic          chit_q;
	logic [47:0]   cmac_q;
	logic          out_full_q;
	out_item_t     out_q, res_q;
	logic          more_q;

	// scan step helpers
	logic          c_end, c_match, p_end, p_match, fail;
	logic [3:0]    att_inc;
	logic [CI-1:0] ci_idx;
	logic [PI-1:0] pi_idx;
	logic          shift_en;
	logic [PW-1:0] shift_from;
	logic          resolve_done, reply_store;

	assign ci_idx  = ci_q[CI-1:0];
	assign pi_idx  = pi_q[PI-1:0];
	assign c_end   = ci_q >= cache_cnt_q;
	assign c_match = !c_end && cache_ip_q[ci_idx] == cmd_q.ip;
	assign p_end   = pi_q >= pend_cnt_q;
	assign p_match = !p_end && pend_ip_q[pi_idx] == cmd_q.ip;
	assign att_inc = pend_att_q[pi_idx] + 4'd1;
	assign fail    = att_inc >= max_attempts;

	assign cmd_ready = state_q == ST_IDLE;
	assign empty     = !out_full_q;
	assign out_item  = out_q;
	assign idle      = state_q == ST_IDLE && !cmd_valid;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = (cmd.mode == MODE_CLEAR) ? ST_IDLE : ST_CSCAN;
					if (cmd.mode == MODE_TICK) state_d = ST_TICK;
				end
			end
			ST_CSCAN: begin
				if (c_end || c_match) begin
					state_d = (cmd_q.mode == MODE_RESOLVE) ? ST_RESOLVE : ST_REPLY;
				end
			end
			ST_RESOLVE: state_d = ST_EMIT;
			ST_REPLY: begin
				if (p_end) state_d = ST_IDLE;
				else if (p_match) state_d = ST_EMIT;
			end
			ST_TICK: begin
				if (p_end) state_d = ST_IDLE;
				else state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_full_q || pop) state_d = more_q ? ret_q : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// results and list edits
	always_comb begin
		resolve_done = state_q == ST_RESOLVE;
		reply_store  = state_q == ST_CSCAN && c_end && cmd_q.mode == MODE_REPLY &&
			cache_cnt_q < CW'(CACHE_ENTRIES);
		shift_en   = (state_q == ST_REPLY && p_match) || (state_q == ST_TICK && !p_end && fail);
		shift_from = pi_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cache_cnt_q <= '0;
			pend_cnt_q  <= '0;
			out_full_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_IDLE && cmd_valid && cmd.mode == MODE_CLEAR) cache_cnt_q <= '0;
			if (reply_store) cache_cnt_q <= cache_cnt_q + CW'(1);
			if (resolve_done && !chit_q && pend_cnt_q < PW'(PENDING_SLOTS)) begin
				pend_cnt_q <= pend_cnt_q + PW'(1);
			end
			if (shift_en) pend_cnt_q <= pend_cnt_q - PW'(1);
			if (state_q == ST_EMIT && (!out_full_q || pop)) out_full_q <= 1'b1;
			else if (pop) out_full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q <= cmd;
			ci_q  <= '0;
			pi_q  <= '0;
		end
		if (state_q == ST_CSCAN) begin
			chit_q <= c_match;
			if (c_match) cmac_q <= cache_mac_q[ci_idx];
			if (!c_end && !c_match) ci_q <= ci_q + CW'(1);
			if (reply_store) begin
				cache_ip_q[cache_cnt_q[CI-1:0]]  <= cmd_q.ip;
				cache_mac_q[cache_cnt_q[CI-1:0]] <= cmd_q.mac;
			end
		end
		if (resolve_done) begin
			res_q.target_ip  <= cmd_q.ip;
			res_q.result_tag <= cmd_q.tag;
			res_q.last       <= 1'b1;
			more_q           <= 1'b0;
			if (chit_q) begin
				res_q.result_kind  <= KIND_HIT;
				res_q.resolved_mac <= cmac_q;
			end else begin
				res_q.resolved_mac <= '0;
				if (pend_cnt_q < PW'(PENDING_SLOTS)) begin
					res_q.result_kind <= KIND_SEND;
					pend_ip_q[pend_cnt_q[PI-1:0]]  <= cmd_q.ip;
					pend_tag_q[pend_cnt_q[PI-1:0]] <= cmd_q.tag[TAG_BITS-1:0];
					pend_att_q[pend_cnt_q[PI-1:0]] <= 4'd0;
				end else begin
					res_q.result_kind <= KIND_FULL;
				end
			end
		end
		if (state_q == ST_REPLY) begin
			if (p_match) begin
				res_q.result_kind  <= KIND_RESOLVED;
				res_q.target_ip    <= cmd_q.ip;
				res_q.resolved_mac <= cmd_q.mac;
				res_q.result_tag   <= 8'(pend_tag_q[pi_idx]);
				res_q.last         <= 1'b1;
				more_q             <= 1'b0;
			end else if (!p_end) begin
				pi_q <= pi_q + PW'(1);
			end
		end
		if (state_q == ST_TICK && !p_end) begin
			res_q.result_kind  <= fail ? KIND_FAILED : KIND_SEND;
			res_q.target_ip    <= pend_ip_q[pi_idx];
			res_q.resolved_mac <= '0;
			res_q.result_tag   <= 8'(pend_tag_q[pi_idx]);
			// last when no entry remains after this one
			res_q.last <= (pi_q + PW'(1)) >= pend_cnt_q;
			more_q     <= (pi_q + PW'(1)) < pend_cnt_q;
			ret_q      <= ST_TICK;
			if (!fail) begin
				pend_att_q[pi_idx] <= att_inc;
				pi_q <= pi_q + PW'(1);
			end
		end
		// close the gap left by the removed entry in one move
		if (shift_en) begin
			for (int j = 0; j < PENDING_SLOTS - 1; j++) begin
				if (PW'(j) >= shift_from) begin
					pend_ip_q[j]  <= pend_ip_q[j+1];
					pend_tag_q[j] <= pend_tag_q[j+1];
					pend_att_q[j] <= pend_att_q[j+1];
				end
			end
		end
		if (state_q == ST_EMIT && (!out_full_q || pop)) out_q <= res_q;
	end
endmodule
`default_nettype wire

// File: rtl/arp_resolver_cache.sv
// top level of the arp resolver cache
// the back end takes a new command only while idle and walks the cache and pending
// entries one per cycle while scanning; each result waits in the emit state while
// the output is full, a retry tick emits one result per pending request, and clear
// cache empties the cache
// reset: arst_n resets cache and pending counts, queue pointers, state and config registers
`default_nettype none
module arp_resolver_cache #(
	parameter int CACHE_ENTRIES = 8,
	parameter int PENDING_SLOTS = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	output logic                     full,
	input  wire arc_pkg::in_item_t   in_item,
	output logic                     empty,
	input  wire logic                pop,
	output arc_pkg::out_item_t       out_item,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	import arc_pkg::*;
	`include "arp_resolver_cache_assert.svh"

	logic [31:0] local_ip_q, subnet_mask_q, gateway_ip_q;
	logic [3:0]  max_attempts_q;
	logic        cmd_valid, cmd_ready, idle;
	cmd_t        cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_ip_q     <= '0;
			subnet_mask_q  <= '0;
			gateway_ip_q   <= '0;
			max_attempts_q <= MAX_ATTEMPTS_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_LOCAL_IP:     local_ip_q     <= cfg_data;
				REG_SUBNET_MASK:  subnet_mask_q  <= cfg_data;
				REG_GATEWAY_IP:   gateway_ip_q   <= cfg_data;
				REG_MAX_ATTEMPTS: max_attempts_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	arc_front u_front (
		.clk, .arst_n, .push, .full, .in_item,
		.local_ip(local_ip_q), .subnet_mask(subnet_mask_q), .gateway_ip(gateway_ip_q),
		.cmd_valid, .cmd_ready, .cmd
	);

	arc_back #(
		.CACHE_ENTRIES(CACHE_ENTRIES), .PENDING_SLOTS(PENDING_SLOTS)
	) u_back (
		.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.max_attempts(max_attempts_q), .empty, .pop, .out_item, .idle
	);

	`ARC_ASSERT(a_result_kind_legal, empty || out_item.result_kind <= KIND_FULL,
		"result kind out of range")
	`ARC_ASSERT_NEXT(a_out_hold, !empty && !pop, !empty && $stable(out_item),
		"waiting result changed")
	`ARC_ASSERT(a_mac_zero, empty || out_item.resolved_mac == 48'd0 ||
		out_item.result_kind == KIND_HIT || out_item.result_kind == KIND_RESOLVED,
		"mac set on a kind that carries none")
	`ARC_ASSERT(a_cfg_idle, !cfg_valid || idle, "register written while busy")
endmodule
`default_nettype wire
